FILE: hdl/idwl_pkg.sv
// Shared types and constants for the identifier whitelist table.
// Used by idwl_ram, idwl_seq and id_whitelist_table; depends on nothing.
package idwl_pkg;

  localparam int ENTRIES_DEF = 32;
  localparam int ID_W        = 32;
  localparam int CMD_W       = 2;
  localparam int ST_W        = 3;
  localparam int OCC_W       = 6;
  localparam logic [OCC_W-1:0] OCC_MAX = {OCC_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_FOUND   = 3'd0,
    ST_ABSENT  = 3'd1,
    ST_ADDED   = 3'd2,
    ST_PRESENT = 3'd3,
    ST_FULL    = 3'd4,
    ST_REMOVED = 3'd5,
    ST_MISS    = 3'd6,
    ST_CLEARED = 3'd7
  } status_t;

  typedef struct packed {
    status_t            status;
    logic [OCC_W-1:0]   occupied;
  } res_t;

endpackage

FILE: hdl/idwl_ram.sv
// Identifier store: one write port, one read port, registered read data.
// Depends on idwl_pkg for the identifier width.
module idwl_ram #(
  parameter int DEPTH = idwl_pkg::ENTRIES_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [idwl_pkg::ID_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [idwl_pkg::ID_W-1:0] rdata
);
  import idwl_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];
  logic [ID_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: hdl/idwl_seq.sv
// Command sequencer: walks the identifier store, holds the valid marks and
// the entry count, and resolves each command. Depends on idwl_pkg.
module idwl_seq #(
  parameter int ENTRIES = idwl_pkg::ENTRIES_DEF,
  localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  idwl_pkg::cmd_t            in_cmd,
  input  logic [idwl_pkg::ID_W-1:0] in_ident,
  output logic                      res_valid,
  input  logic                      res_ready,
  output idwl_pkg::res_t            res,
  output logic                      mem_re,
  output logic [AW-1:0]             mem_raddr,
  input  logic [idwl_pkg::ID_W-1:0] mem_rdata,
  output logic                      mem_we,
  output logic [AW-1:0]             mem_waddr,
  output logic [idwl_pkg::ID_W-1:0] mem_wdata
);
  import idwl_pkg::*;

  localparam int CW0   = $clog2(ENTRIES + 1);
  localparam int CNT_W = (CW0 > OCC_W) ? CW0 : OCC_W;
  localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [ID_W-1:0]    ident_r, ident_nxt;
  logic [AW-1:0]      iss_idx_r, iss_idx_nxt;
  logic               iss_done_r, iss_done_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic               free_found_r, free_found_nxt;
  logic [AW-1:0]      free_idx_r, free_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  status_t            status_r, status_nxt;

  logic          hit, cur_free, last, free_any;
  logic [AW-1:0] free_sel;

  // The compare stage sees the data read in the previous cycle at cmp_idx_r.
  assign hit      = cmp_vld_r && valid_r[cmp_idx_r] && (mem_rdata == ident_r);
  assign cur_free = cmp_vld_r && !valid_r[cmp_idx_r];
  assign last     = cmp_vld_r && (cmp_idx_r == LAST_IDX);
  assign free_any = free_found_r || cur_free;
  assign free_sel = free_found_r ? free_idx_r : cmp_idx_r;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    ident_nxt      = ident_r;
    iss_idx_nxt    = iss_idx_r;
    iss_done_nxt   = iss_done_r;
    cmp_vld_nxt    = cmp_vld_r;
    cmp_idx_nxt    = cmp_idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    count_nxt      = count_r;
    status_nxt     = status_r;
    mem_re         = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_cmd;
          ident_nxt      = in_ident;
          iss_idx_nxt    = '0;
          iss_done_nxt   = 1'b0;
          cmp_vld_nxt    = 1'b0;
          free_found_nxt = 1'b0;
          if (in_cmd == CMD_CLEAR) begin
            valid_nxt  = '0;
            count_nxt  = '0;
            status_nxt = ST_CLEARED;
            state_nxt  = S_DONE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!iss_done_r) begin
          mem_re       = 1'b1;
          iss_done_nxt = (iss_idx_r == LAST_IDX);
          iss_idx_nxt  = (iss_idx_r == LAST_IDX) ? iss_idx_r : iss_idx_r + AW'(1);
        end
        cmp_vld_nxt = !iss_done_r;
        cmp_idx_nxt = iss_idx_r;
        if (cur_free && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = cmp_idx_r;
        end
        if (hit || last) begin
          state_nxt   = S_DONE;
          cmp_vld_nxt = 1'b0;
          unique case (cmd_r)
            CMD_LOOKUP: status_nxt = hit ? ST_FOUND : ST_ABSENT;
            CMD_ADD: begin
              if (hit) begin
                status_nxt = ST_PRESENT;
              end else if (free_any) begin
                mem_we              = 1'b1;
                valid_nxt[free_sel] = 1'b1;
                count_nxt           = count_r + CNT_W'(1);
                status_nxt          = ST_ADDED;
              end else begin
                status_nxt = ST_FULL;
              end
            end
            CMD_REMOVE: begin
              if (hit) begin
                valid_nxt[cmp_idx_r] = 1'b0;
                count_nxt            = count_r - CNT_W'(1);
                status_nxt           = ST_REMOVED;
              end else begin
                status_nxt = ST_MISS;
              end
            end
            CMD_CLEAR: status_nxt = ST_CLEARED;
          endcase
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      iss_done_r   <= 1'b0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
    end else begin
      state_r      <= state_nxt;
      iss_done_r   <= iss_done_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      valid_r      <= valid_nxt;
      count_r      <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    ident_r    <= ident_nxt;
    iss_idx_r  <= iss_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    free_idx_r <= free_idx_nxt;
    status_r   <= status_nxt;
  end

  assign in_ready     = (state_r == S_IDLE);
  assign res_valid    = (state_r == S_DONE);
  assign res.status   = status_r;
  assign res.occupied = (count_r > CNT_W'(OCC_MAX)) ? OCC_MAX : count_r[OCC_W-1:0];

  assign mem_raddr = iss_idx_r;
  assign mem_waddr = free_sel;
  assign mem_wdata = ident_r;

  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    count_r == CNT_W'($countones(valid_r)))
    else $error("entry count differs from the number of valid marks");

  a_add_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !valid_r[mem_waddr] && (cmd_r == CMD_ADD) && !hit)
    else $error("add wrote over a valid entry");

  a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (state_nxt == S_DONE) && (status_nxt == ST_ADDED)
    |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("add did not bump the entry count");

  a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_vld_r |-> (state_r == S_SCAN))
    else $error("compare stage active outside a scan");

endmodule

FILE: hdl/id_whitelist_table.sv
// Top level of the identifier whitelist table: command sequencer, identifier
// store and output register. Depends on idwl_pkg, idwl_ram and idwl_seq.
//
// Usage:
//   The input channel carries one command per transaction: in_tuser holds
//   the command (lookup, add, remove, clear) and in_tdata the identifier.
//   The result channel returns exactly one transaction per command:
//   out_tuser holds the status, out_tdata the number of valid entries.
//   Commands are worked one at a time. Lookup, add and remove walk the
//   store one entry per cycle through its single read port, stopping at the
//   first valid match: each read is registered in the store, compared in
//   the compare stage, and a match or the last entry ends the scan. Clear
//   skips the scan. The next command is taken in the cycle after the result
//   leaves the sequencer; no new command is taken while one is in work.
//   Reset (rst_n low, synchronous) clears all valid marks and the count;
//   the identifier store itself is never swept.
//   When the receiver stalls, a finished result waits in the output
//   register while the sequencer takes and works the next command; that
//   one then holds until the register frees up.
module id_whitelist_table #(
  parameter int ENTRIES = idwl_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] ident
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [5:0] occupied, [7:6] zero
  output logic [2:0]  out_tuser   // [2:0] status
);
  import idwl_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            res_valid, res_ready;
  res_t            res;
  logic            mem_re, mem_we;
  logic [AW-1:0]   mem_raddr, mem_waddr;
  logic [ID_W-1:0] mem_rdata, mem_wdata;

  logic            out_valid_r, out_valid_nxt;
  res_t            out_res_r, out_res_nxt;

  idwl_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (cmd_t'(in_tuser)),
    .in_ident  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  idwl_ram #(.DEPTH(ENTRIES)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.status;
  assign out_tdata  = {2'b00, out_res_r.occupied};

endmodule
